@@ sv/esd_pkg.sv @@
// shared types and constants for the escape sequence decoder
package esd_pkg;

  // result queue geometry
  localparam int QDepth = 4;
  localparam int QAw = $clog2(QDepth);

  // ascii codes used by the decoder
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] Ch0 = 8'h30;
  localparam logic [7:0] Ch7 = 8'h37;
  localparam logic [7:0] Ch9 = 8'h39;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowF = 8'h66;
  localparam logic [7:0] ChUpA = 8'h41;
  localparam logic [7:0] ChUpF = 8'h46;
  localparam logic [7:0] ChLowB = 8'h62;
  localparam logic [7:0] ChLowN = 8'h6E;
  localparam logic [7:0] ChLowR = 8'h72;
  localparam logic [7:0] ChLowT = 8'h74;
  localparam logic [7:0] ChLowV = 8'h76;
  localparam logic [7:0] ChLowX = 8'h78;
  localparam logic [7:0] ChLowU = 8'h75;
  localparam logic [7:0] ChUpU = 8'h55;

  // control codes of the single-letter escapes
  localparam logic [31:0] CodeBell = 32'd7;
  localparam logic [31:0] CodeBackspace = 32'd8;
  localparam logic [31:0] CodeFormFeed = 32'd12;
  localparam logic [31:0] CodeNewline = 32'd10;
  localparam logic [31:0] CodeReturn = 32'd13;
  localparam logic [31:0] CodeTab = 32'd9;
  localparam logic [31:0] CodeVtab = 32'd11;

  // digit limits of the bounded runs
  localparam logic [3:0] LimitU4 = 4'd4;
  localparam logic [3:0] LimitU8 = 4'd8;
  localparam logic [3:0] LimitOct = 4'd3;

  // one result item
  typedef struct packed {
    logic [31:0] code;
    logic        run_last;
    logic        string_end;
    logic        dangling;
  } res_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } step_t;

endpackage

@@ sv/esd_if.sv @@
// valid/ready channel interfaces for source bytes and decoded codes
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

interface esd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] code;
  logic        run_last;
  logic        string_end;
  logic        dangling;

  modport source (output valid, output code, output run_last, output string_end,
                  output dangling, input ready);
  modport sink (input valid, input code, input run_last, input string_end,
                input dangling, output ready);
endinterface

@@ sv/esd_decode.sv @@
// escape decoding state and per-byte result logic
module esd_decode
  import esd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] ch,
  input  logic       last,
  output step_t      step
);

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_HEXX  = 3'd2,
    MODE_HEXU4 = 3'd3,
    MODE_HEXU8 = 3'd4,
    MODE_OCT   = 3'd5
  } mode_t;

  mode_t       mode, mode_next;
  logic [31:0] accum, accum_next;
  logic [3:0]  digit_count, digit_count_next;

  // state registers, updated on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PLAIN;
      accum <= '0;
      digit_count <= '0;
    end else if (take) begin
      mode <= mode_next;
      accum <= accum_next;
      digit_count <= digit_count_next;
    end
  end

  // classify byte, step the run and collect up to two results
  always_comb begin
    logic        hex_ok, oct_ok, d_ok, is_run, consumed, hit;
    logic [3:0]  hex_val, cnt_inc;
    logic [31:0] acc_dig, code_v;
    logic [1:0]  nn;
    res_t        r0, r1;

    hex_ok = 1'b0;
    hex_val = '0;
    if (ch >= Ch0 && ch <= Ch9) begin
      hex_ok = 1'b1;
      hex_val = 4'(ch - Ch0);
    end else if (ch >= ChLowA && ch <= ChLowF) begin
      hex_ok = 1'b1;
      hex_val = 4'(ch - ChLowA + 8'd10);
    end else if (ch >= ChUpA && ch <= ChUpF) begin
      hex_ok = 1'b1;
      hex_val = 4'(ch - ChUpA + 8'd10);
    end
    oct_ok = (ch >= Ch0) && (ch <= Ch7);

    is_run = (mode == MODE_HEXX) || (mode == MODE_HEXU4) || (mode == MODE_HEXU8) ||
             (mode == MODE_OCT);
    d_ok = (mode == MODE_OCT) ? oct_ok : hex_ok;
    acc_dig = (mode == MODE_OCT) ? {accum[28:0], ch[2:0]} : {accum[27:0], hex_val};
    cnt_inc = (digit_count == 4'd15) ? digit_count : digit_count + 4'd1;
    hit = ((mode == MODE_HEXU4) && (cnt_inc >= LimitU4)) ||
          ((mode == MODE_HEXU8) && (cnt_inc >= LimitU8)) ||
          ((mode == MODE_OCT) && (cnt_inc >= LimitOct));

    mode_next = mode;
    accum_next = accum;
    digit_count_next = digit_count;
    consumed = 1'b0;
    code_v = '0;
    nn = 2'd0;
    r0 = '0;
    r1 = '0;

    if (is_run) begin
      if (d_ok) begin
        consumed = 1'b1;
        if (hit) begin
          r0.code = acc_dig;
          nn = 2'd1;
          mode_next = MODE_PLAIN;
          accum_next = '0;
          digit_count_next = '0;
        end else begin
          accum_next = acc_dig;
          digit_count_next = cnt_inc;
        end
      end else begin
        // run ends on a non-digit, byte is handled below
        r0.code = accum;
        nn = 2'd1;
        mode_next = MODE_PLAIN;
        accum_next = '0;
        digit_count_next = '0;
      end
    end else if (mode == MODE_ESC) begin
      consumed = 1'b1;
      mode_next = MODE_PLAIN;
      code_v = {24'd0, ch};
      unique case (ch)
        ChLowA:  code_v = CodeBell;
        ChLowB:  code_v = CodeBackspace;
        ChLowF:  code_v = CodeFormFeed;
        ChLowN:  code_v = CodeNewline;
        ChLowR:  code_v = CodeReturn;
        ChLowT:  code_v = CodeTab;
        ChLowV:  code_v = CodeVtab;
        ChLowX:  mode_next = MODE_HEXX;
        ChLowU:  mode_next = MODE_HEXU4;
        ChUpU:   mode_next = MODE_HEXU8;
        default: begin
          if (oct_ok) begin
            mode_next = MODE_OCT;
            accum_next = {29'd0, ch[2:0]};
            digit_count_next = 4'd1;
          end
        end
      endcase
      if (mode_next == MODE_PLAIN) begin
        r0.code = code_v;
        nn = 2'd1;
      end
    end else begin
      // plain text, unused codes fall in here too
      mode_next = MODE_PLAIN;
    end

    // byte not taken by an escape: backslash or literal
    if (!consumed) begin
      if (ch == ChBackslash) begin
        mode_next = MODE_ESC;
      end else if (nn == 2'd0) begin
        r0.code = {24'd0, ch};
        nn = 2'd1;
      end else begin
        r1.code = {24'd0, ch};
        nn = 2'd2;
      end
    end

    // end of string flushes an open run or flags a dangling backslash
    if (last) begin
      if ((mode_next == MODE_HEXX) || (mode_next == MODE_HEXU4) ||
          (mode_next == MODE_HEXU8) || (mode_next == MODE_OCT) ||
          (mode_next == MODE_ESC)) begin
        if (nn == 2'd0) begin
          r0.code = (mode_next == MODE_ESC) ? 32'd0 : accum_next;
          r0.dangling = (mode_next == MODE_ESC);
          nn = 2'd1;
        end else begin
          r1.code = (mode_next == MODE_ESC) ? 32'd0 : accum_next;
          r1.dangling = (mode_next == MODE_ESC);
          nn = 2'd2;
        end
      end
      mode_next = MODE_PLAIN;
      accum_next = '0;
      digit_count_next = '0;
    end

    // mark the final result of this byte
    if (nn == 2'd1) begin
      r0.run_last = 1'b1;
      r0.string_end = last;
    end else if (nn == 2'd2) begin
      r1.run_last = 1'b1;
      r1.string_end = last;
    end

    step.n = nn;
    step.r0 = r0;
    step.r1 = r1;
  end

  // a byte can never yield more than two results
  a_n_bound: assert property (@(posedge clk) disable iff (rst) take |-> step.n != 2'd3)
    else $error("more than two results for one byte");
  // the end of a string always yields a result
  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (take && last) |-> step.n != 2'd0)
    else $error("string end without a result");
  // string end returns to plain text
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (take && last) |=> (mode == MODE_PLAIN && accum == 32'd0 && digit_count == 4'd0))
    else $error("state not cleared at string end");

endmodule

@@ sv/escape_sequence_decoder_core.sv @@
// escape sequence decoder top level: decode step feeding a small result queue
// a byte's results are registered in the result queue, offered from its head
// throughput: one byte per cycle while ready; a byte's two results leave in turn
// input ready while the result queue has room for two results
// reset (rst, synchronous): plain text mode, run cleared, result queue empty
// no clearing pass after reset
module escape_sequence_decoder_core
  import esd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  esd_in_if.sink    bytes,
  esd_out_if.source codes
);

  step_t            step;
  res_t             q [QDepth];
  logic [QAw-1:0]   head, tail;
  logic [QAw:0]     count;
  logic             take, pop;
  logic [QAw:0]     push_n;

  assign bytes.ready = (count <= (QAw + 1)'(QDepth - 2));
  assign take = bytes.valid && bytes.ready;
  assign pop = codes.valid && codes.ready;
  assign push_n = take ? (QAw + 1)'(step.n) : '0;

  esd_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .ch   (bytes.ch),
    .last (bytes.last),
    .step (step)
  );

  // result queue storage
  always_ff @(posedge clk) begin
    if (take && step.n != 2'd0) begin
      q[tail] <= step.r0;
    end
    if (take && step.n == 2'd2) begin
      q[tail + QAw'(1)] <= step.r1;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      tail <= tail + QAw'(push_n);
      if (pop) begin
        head <= head + QAw'(1);
      end
      count <= count + push_n - (QAw + 1)'(pop);
    end
  end

  // output transfer from the queue head
  assign codes.valid = (count != '0);
  assign codes.code = q[head].code;
  assign codes.run_last = q[head].run_last;
  assign codes.string_end = q[head].string_end;
  assign codes.dangling = q[head].dangling;

  // queue never overfills
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (QAw + 1)'(QDepth))
    else $error("result queue overflow");
  // fill count tracks pushes and pops
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count) + $past(push_n) - (QAw + 1)'($past(pop)))
    else $error("result queue count mismatch");
  // every accepted string end yields an output within the queue
  a_end_pushed: assert property (@(posedge clk) disable iff (rst)
    (take && bytes.last) |=> count != '0)
    else $error("string end left no queued result");

endmodule

@@ dv/esd_tb_pkg.sv @@
// decoder mode codes and the code scoreboard for the escape sequence decoder testbench
`timescale 1ns / 100ps
package esd_tb_pkg;
  import esd_pkg::*;

  // decoder modes as the expected-code model tracks them
  typedef enum logic [2:0] {
    DecPlain  = 3'd0,
    DecEsc    = 3'd1,
    DecHexAny = 3'd2,
    DecHex4   = 3'd3,
    DecHex8   = 3'd4,
    DecOct    = 3'd5
  } dec_mode_t;

  localparam int ReportLimit = 10;

  class esd_scoreboard_t;
    dec_mode_t   mode = DecPlain;
    logic [31:0] accum = '0;
    logic [3:0]  ndigits = '0;
    res_t        step_q[$];
    res_t        expected_q[$];
    int unsigned failures = 0;

    function void clear_run();
      mode = DecPlain;
      accum = '0;
      ndigits = '0;
    endfunction

    function void add_result(logic [31:0] cd, logic dg);
      res_t r;
      r = '0;
      r.code = cd;
      r.dangling = dg;
      step_q = {step_q, r};
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // byte transfer: work out the codes it causes and queue them
    function void note_byte(logic [7:0] c, logic fin);
      int          digit;
      logic        taken;
      logic [3:0]  limit;
      logic [31:0] cd;
      step_q.delete();
      taken = 1'b0;
      if (mode inside {DecHexAny, DecHex4, DecHex8, DecOct}) begin
        // digit run: extend it or close it
        digit = -1;
        if (c >= Ch0 && c <= Ch9) digit = int'(c) - int'(Ch0);
        else if (c >= ChLowA && c <= ChLowF) digit = int'(c) - int'(ChLowA) + 10;
        else if (c >= ChUpA && c <= ChUpF) digit = int'(c) - int'(ChUpA) + 10;
        if (mode == DecOct && (c < Ch0 || c > Ch7)) digit = -1;
        if (digit >= 0) begin
          if (mode == DecOct) accum = {accum[28:0], 3'b000} | 32'(digit);
          else accum = {accum[27:0], 4'h0} | 32'(digit);
          if (ndigits != 4'd15) ndigits = ndigits + 4'd1;
          case (mode)
            DecHex4: limit = LimitU4;
            DecHex8: limit = LimitU8;
            DecOct: limit = LimitOct;
            default: limit = '0;
          endcase
          if (limit != '0 && ndigits >= limit) begin
            add_result(accum, 1'b0);
            clear_run();
          end
          taken = 1'b1;
        end else begin
          add_result(accum, 1'b0);
          clear_run();
        end
      end else if (mode == DecEsc) begin
        // byte after a backslash
        taken = 1'b1;
        mode = DecPlain;
        cd = {24'h0, c};
        case (c)
          ChLowA: cd = CodeBell;
          ChLowB: cd = CodeBackspace;
          ChLowF: cd = CodeFormFeed;
          ChLowN: cd = CodeNewline;
          ChLowR: cd = CodeReturn;
          ChLowT: cd = CodeTab;
          ChLowV: cd = CodeVtab;
          ChLowX: mode = DecHexAny;
          ChLowU: mode = DecHex4;
          ChUpU: mode = DecHex8;
          default: begin
            if (c >= Ch0 && c <= Ch7) begin
              mode = DecOct;
              accum = 32'(c - Ch0);
              ndigits = 4'd1;
            end
          end
        endcase
        if (mode == DecPlain) add_result(cd, 1'b0);
      end else begin
        mode = DecPlain;
      end

      // byte not used by an escape is handled as plain text
      if (!taken) begin
        if (c == ChBackslash) mode = DecEsc;
        else add_result({24'h0, c}, 1'b0);
      end

      // end of string flushes an open run or a dangling backslash
      if (fin) begin
        if (mode inside {DecHexAny, DecHex4, DecHex8, DecOct}) add_result(accum, 1'b0);
        else if (mode == DecEsc) add_result('0, 1'b1);
        clear_run();
      end

      if (step_q.size() > 0) begin
        step_q[step_q.size() - 1].run_last = 1'b1;
        step_q[step_q.size() - 1].string_end = fin;
      end
      expected_q = {expected_q, step_q};
    endfunction

    // code transfer: compare with the oldest expected code
    function void check_code(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= ReportLimit)
          $display("unexpected code transfer: code=%h run_last=%b string_end=%b dangling=%b",
                   got.code, got.run_last, got.string_end, got.dangling);
        return;
      end
      want = expected_q.pop_front();
      if (got.code !== want.code || got.run_last !== want.run_last ||
          got.string_end !== want.string_end || got.dangling !== want.dangling) begin
        failures++;
        if (failures <= ReportLimit)
          $display("code mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
                   want.code, want.run_last, want.string_end, want.dangling,
                   got.code, got.run_last, got.string_end, got.dangling);
      end
    endfunction
  endclass

endpackage

@@ dv/escape_sequence_decoder_core_tb.sv @@
// testbench for escape_sequence_decoder_core: byte stream stimulus checked against a code scoreboard
`timescale 1ns / 100ps
module escape_sequence_decoder_core_tb;
  import esd_pkg::*;
  import esd_tb_pkg::*;

  localparam int NumItems = 700;
  localparam int CycleLimit = 100000;
  localparam int IdlePct = 31;
  localparam int HoldCycles = 80;
  localparam int HoldAt = 250;
  localparam int PauseAt = 450;
  localparam int QuietFrom = 500;
  localparam int QuietTo = 620;
  localparam int DrainCycles = 8;

  // random token kinds of a generated string
  typedef enum int {
    TokPlain, TokLetter, TokHexAny, TokHex4, TokHex8, TokOct, TokOther
  } tok_t;

  logic clk = 1'b0;
  logic rst;

  esd_in_if  bytes_if ();
  esd_out_if codes_if ();

  escape_sequence_decoder_core uut (
    .clk  (clk),
    .rst  (rst),
    .bytes(bytes_if),
    .codes(codes_if)
  );

  esd_scoreboard_t sb = new;
  int unsigned     bytes_sent = 0;
  int unsigned     cycles = 0;
  logic            hold_done = 1'b0;
  int              hold_left = 0;
  logic [7:0]      text_q[$];

  always #2 clk = ~clk;

  // stretch with no idling on either side
  function automatic logic quiet();
    return bytes_sent >= QuietFrom && bytes_sent < QuietTo;
  endfunction

  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return Ch0 + 8'(v);
    return ($urandom_range(0, 1) ? ChUpA : ChLowA) + 8'(v - 10);
  endfunction

  // append one byte to the string being built
  function automatic void put_text_byte(input logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  // one byte transfer on the input channel
  task automatic send_byte(input logic [7:0] c, input logic fin);
    while (!quiet() && $urandom_range(0, 99) < IdlePct) begin
      bytes_if.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_if.valid <= 1'b1;
    bytes_if.ch <= c;
    bytes_if.last <= fin;
    @(posedge clk);
    while (!bytes_if.ready) @(posedge clk);
    sb.note_byte(c, fin);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
  endtask

  // build one random string, mostly well-formed escapes
  task automatic gen_text();
    int   ntok;
    int   ndig;
    tok_t kind;
    logic [7:0] letters[7];
    letters = '{ChLowA, ChLowB, ChLowF, ChLowN, ChLowR, ChLowT, ChLowV};
    text_q.delete();
    ntok = $urandom_range(1, 8);
    for (int t = 0; t < ntok; t++) begin
      kind = tok_t'($urandom_range(0, 9) < 3 ? TokPlain : $urandom_range(1, 6));
      if (kind != TokPlain) put_text_byte(ChBackslash);
      case (kind)
        TokPlain: put_text_byte(8'($urandom_range(0, 255)));
        TokLetter: put_text_byte(letters[$urandom_range(0, 6)]);
        TokOther: put_text_byte(8'($urandom_range(0, 255)));
        TokOct: begin
          ndig = $urandom_range(1, 4);
          for (int d = 0; d < ndig; d++) put_text_byte(Ch0 + 8'($urandom_range(0, 7)));
        end
        default: begin
          case (kind)
            TokHexAny: begin
              put_text_byte(ChLowX);
              ndig = $urandom_range(0, 11);
            end
            TokHex4: begin
              put_text_byte(ChLowU);
              ndig = $urandom_range(0, 5);
            end
            default: begin
              put_text_byte(ChUpU);
              ndig = $urandom_range(0, 9);
            end
          endcase
          for (int d = 0; d < ndig; d++) put_text_byte(rand_hex());
        end
      endcase
    end
    if ($urandom_range(0, 9) == 0) put_text_byte(ChBackslash);
  endtask

  // receiver: check code transfers, random idling and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      codes_if.ready <= 1'b0;
    end else begin
      if (codes_if.valid && codes_if.ready)
        sb.check_code('{code: codes_if.code, run_last: codes_if.run_last,
                        string_end: codes_if.string_end, dangling: codes_if.dangling});
      if (!hold_done && bytes_sent >= HoldAt) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        codes_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        codes_if.ready <= 1'b0;
      end else begin
        codes_if.ready <= quiet() || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic paused;
    paused = 1'b0;
    rst <= 1'b1;
    bytes_if.valid <= 1'b0;
    bytes_if.ch <= '0;
    bytes_if.last <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: byte extremes, escapes, runs, end cases
    send_byte(ChUpA, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("\\t\\xfG\\u1234\\123\\78\\\\\\uz", 1'b0);
    send_text("\\x", 1'b1);
    send_text("\\UA", 1'b1);
    send_text("\\", 1'b1);

    // random strings
    while (bytes_sent < NumItems) begin
      if (!paused && bytes_sent >= PauseAt) begin
        paused = 1'b1;
        bytes_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      gen_text();
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    end
    bytes_if.valid <= 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
